/* rtl/assert_macros.svh */
// assertion macros used by the interpolator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/grbf_pkg.sv */
// shared types and constants of the gaussian rbf height interpolator
package grbf_pkg;

  localparam int MAX_POINTS_DEF     = 64;
  localparam int EXP_TABLE_SIZE_DEF = 256;

  localparam int CoordW  = 32;
  localparam int HeightW = 48;
  localparam int SlotW   = 6;
  localparam int ActW    = 7;

  localparam logic [0:0] REG_INV_SIGMA = 1'b0;
  localparam logic [0:0] REG_ACTIVE    = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] w;
  } center_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } eval_ctrl_t;

endpackage

/* rtl/grbf_cell.sv */
// one storage cell of the center ring
module grbf_cell (
  input  logic              clk,
  input  logic              shift,
  input  grbf_pkg::center_t nb,
  input  logic              wr_en,
  input  grbf_pkg::center_t wr_data,
  output grbf_pkg::center_t q
);
  import grbf_pkg::*;

  center_t held;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held <= wr_data;
    end else if (shift) begin
      held <= nb;
    end
  end

  assign q = held;
endmodule

/* rtl/grbf_eval.sv */
// pipelined gaussian kernel evaluation and saturating accumulator
module grbf_eval #(
  parameter int TabSize = grbf_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  grbf_pkg::eval_ctrl_t               ctrl,
  input  grbf_pkg::center_t                  ctr,
  input  logic signed [grbf_pkg::CoordW-1:0] qx,
  input  logic signed [grbf_pkg::CoordW-1:0] qy,
  input  logic [31:0]                        inv_sigma,
  output logic signed [grbf_pkg::HeightW-1:0] acc
);
  import grbf_pkg::*;

  localparam int IdxW = $clog2(TabSize + 1);
  localparam int PW   = 21 + IdxW + 1;
  localparam logic [20:0] TSat = 21'h100000;
  localparam logic signed [HeightW:0] HMax = {2'b00, {(HeightW-1){1'b1}}};
  localparam logic signed [HeightW:0] HMin = {2'b11, {(HeightW-1){1'b0}}};

  typedef logic [16:0] tab_t [TabSize+1];

  // shift and subtract quotient, only evaluated while building the table
  function automatic logic [63:0] const_quot(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tab_t build_tab();
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r32;
    logic [63:0] e;
    tab_t        tb;
    term = 64'd1 << 58;
    sum  = term;
    e    = 64'd1 << 32;
    for (int k = 1; k < 48; k++) begin
      if (term != 64'd0) begin
        term = const_quot(term * 64'd16, 64'(TabSize) * 64'(k));
        if (k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    r32 = (sum + (64'd1 << 25)) >> 26;
    for (int k = 0; k <= TabSize; k++) begin
      if (k > 0) e = (e * r32 + (64'd1 << 31)) >> 32;
      tb[k] = 17'((e + 64'h8000) >> 16);
    end
    return tb;
  endfunction

  localparam tab_t ExpTab = build_tab();

  // stage valids
  logic [7:0] v;

  logic [31:0] adx, ady;
  logic signed [CoordW-1:0] w1, w2, w3, w4, w5, w6, w7;
  logic [63:0] xx, yy, d2, hi, lo;
  logic [20:0] t;
  logic [16:0] ea, dab, e;
  logic [15:0] f;
  logic signed [33:0] term;

  logic signed [32:0] dx, dy;
  logic [64:0] dsum;
  logic [32:0] tt;
  logic [PW-1:0] p;
  logic [PW-17:0] ip;
  logic [IdxW-1:0] ia, ib;
  logic [15:0] fp;
  logic [32:0] fprod;
  logic signed [49:0] prod;
  logic signed [HeightW:0] asum;

  always_comb begin
    dx = {qx[31], qx} - {ctr.x[31], ctr.x};
    dy = {qy[31], qy} - {ctr.y[31], ctr.y};
    dsum = {1'b0, xx} + {1'b0, yy};
    tt = {12'd0, hi[20:0]} + {1'b0, lo[63:32]};
    p  = (PW'(t) * PW'(TabSize)) >> 4;
    ip = p[PW-1:16];
    if (ip >= (PW-16)'(TabSize)) begin
      ia = IdxW'(TabSize);
      ib = IdxW'(TabSize);
      fp = 16'd0;
    end else begin
      ia = ip[IdxW-1:0];
      ib = ip[IdxW-1:0] + IdxW'(1);
      fp = p[15:0];
    end
    fprod = dab * f;
    prod  = w7 * $signed({1'b0, e});
    asum  = {acc[HeightW-1], acc} + (HeightW+1)'(term);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      v <= '0;
    end else begin
      v <= {v[6:0], ctrl.valid};
    end
    adx <= dx[32] ? 32'(-dx) : dx[31:0];
    ady <= dy[32] ? 32'(-dy) : dy[31:0];
    w1 <= ctr.w;
    xx <= adx * adx;
    yy <= ady * ady;
    w2 <= w1;
    d2 <= dsum[64] ? {64{1'b1}} : dsum[63:0];
    w3 <= w2;
    hi <= d2[63:32] * inv_sigma;
    lo <= d2[31:0] * inv_sigma;
    w4 <= w3;
    // t saturates at 16.0
    if (hi >= 64'(TSat)) t <= TSat;
    else if (tt > 33'(TSat)) t <= TSat;
    else t <= tt[20:0];
    w5 <= w4;
    ea  <= ExpTab[ia];
    dab <= ExpTab[ia] - ExpTab[ib];
    f   <= fp;
    w6  <= w5;
    e   <= ea - fprod[32:16];
    w7  <= w6;
    term <= 34'(prod >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
    end else if (v[7]) begin
      if (asum > HMax) acc <= HMax[HeightW-1:0];
      else if (asum < HMin) acc <= HMin[HeightW-1:0];
      else acc <= asum[HeightW-1:0];
    end
  end
endmodule

/* rtl/gaussian_rbf_height_interpolator.sv */
// Gaussian RBF height interpolator top level.
// Input channel (in_valid/in_stall) carries one word: mode 0 loads a center
// (pos_x, pos_y, weight) into slot; mode 1 queries the height at pos_x, pos_y.
// Output channel (out_valid/out_stall) gives one height word per query.
// Registers are written through wr_en/wr_addr/wr_data; the user must write
// them only while the block is idle, which the block does not enforce. A
// load keeps the block idle. Centers sit in a ring of MAX_POINTS cells; a
// query rotates the ring once, feeding one center a cycle into the kernel
// pipeline, then drains it; the height is ready in the FINISH state, and
// the next word is taken once the control is back in idle.
// in_stall is high while a query runs. The result sits in an output register;
// the next word is taken while it waits, and a following query only holds at
// its end until the receiver takes the earlier result.
// Reset (synchronous) returns the control to idle, sets inv_two_sigma_sq to
// 1.0 and active_points to 0; stored centers are undefined until loaded.
`include "assert_macros.svh"
module gaussian_rbf_height_interpolator #(
  parameter int MAX_POINTS     = grbf_pkg::MAX_POINTS_DEF,
  parameter int EXP_TABLE_SIZE = grbf_pkg::EXP_TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [0:0]                          wr_addr,
  input  logic [31:0]                         wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [grbf_pkg::SlotW-1:0]          slot,
  input  logic signed [grbf_pkg::CoordW-1:0]  pos_x,
  input  logic signed [grbf_pkg::CoordW-1:0]  pos_y,
  input  logic signed [grbf_pkg::CoordW-1:0]  weight,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [grbf_pkg::HeightW-1:0] height
);
  import grbf_pkg::*;

  localparam int Drain = 10;
  localparam int CntW  = $clog2(MAX_POINTS + Drain + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic [31:0] inv_two_sigma_sq;
  logic [ActW-1:0] active_points;
  logic signed [CoordW-1:0] qx, qy;
  logic signed [HeightW-1:0] acc;

  center_t cell_q [MAX_POINTS];
  center_t wr_word;
  eval_ctrl_t ctrl;
  logic in_acc, shift, issue, out_load;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign shift    = (state == S_RUN);
  assign issue    = shift && (32'(cnt) < 32'(active_points));
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);
  assign wr_word  = '{x: pos_x, y: pos_y, w: weight};
  assign ctrl     = '{clear: in_acc && (mode == MODE_QUERY), valid: issue};

  // ring: each cell takes its upper neighbor, the last wraps to the head
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    grbf_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .nb      (cell_q[(i == MAX_POINTS - 1) ? 0 : i + 1]),
      .wr_en   (in_acc && (mode == MODE_LOAD) && (32'(slot) == i)),
      .wr_data (wr_word),
      .q       (cell_q[i])
    );
  end

  grbf_eval #(.TabSize(EXP_TABLE_SIZE)) u_eval (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .ctr       (cell_q[0]),
    .qx        (qx),
    .qy        (qy),
    .inv_sigma (inv_two_sigma_sq),
    .acc       (acc)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_acc && mode == MODE_QUERY) state_next = S_RUN;
      end
      S_RUN: begin
        if (cnt == CntW'(MAX_POINTS - 1)) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      S_DRAIN: begin
        if (cnt == CntW'(Drain - 1)) begin
          cnt_next   = '0;
          state_next = S_FINISH;
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      S_FINISH: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      inv_two_sigma_sq <= 32'h0001_0000;
      active_points    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (wr_en) begin
        case (wr_addr)
          REG_INV_SIGMA: inv_two_sigma_sq <= wr_data;
          REG_ACTIVE:    active_points    <= wr_data[ActW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == MODE_QUERY) begin
      qx <= pos_x;
      qy <= pos_y;
    end
    if (out_load) height <= acc;
  end

  `ASSERT_HOLDS(a_issue_in_run, clk, rst, issue |-> state == S_RUN)
  `ASSERT_HOLDS(a_out_from_finish, clk, rst, $rose(out_valid) |-> $past(state == S_FINISH))
  `ASSERT_NEVER(a_cnt_bound, clk, rst, 32'(cnt) > MAX_POINTS + Drain)
endmodule

/* bench/tb_gaussian_rbf_height_interpolator.sv */
// testbench for the gaussian rbf height interpolator: directed and random words checked against a predictor
`timescale 1ns / 1ps
module tb_gaussian_rbf_height_interpolator;
  import grbf_pkg::*;

  localparam int NPTS = 64;
  localparam int TBL = 256;
  localparam logic [63:0] T_SAT = 64'h100000;
  localparam longint H_MAX = 64'sd140737488355327;
  localparam longint H_MIN = -64'sd140737488355328;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [0:0] wr_addr = REG_INV_SIGMA;
  logic [31:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_LOAD;
  logic [SlotW-1:0] slot = '0;
  logic signed [CoordW-1:0] pos_x = '0;
  logic signed [CoordW-1:0] pos_y = '0;
  logic signed [CoordW-1:0] weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [HeightW-1:0] height;

  gaussian_rbf_height_interpolator uut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .slot(slot),
    .pos_x(pos_x), .pos_y(pos_y), .weight(weight),
    .out_valid(out_valid), .out_stall(out_stall), .height(height)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] exp_tab [0:TBL];
  logic signed [31:0] ctr_x [0:NPTS-1];
  logic signed [31:0] ctr_y [0:NPTS-1];
  logic signed [31:0] ctr_w [0:NPTS-1];
  logic [31:0] inv_sig;
  int act_pts;
  logic [47:0] height_q [$];

  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_burst = 0;

  task automatic build_exp_table();
    logic [63:0] term, sum, r32, e;
    term = 64'd1 << 58;
    sum = term;
    e = 64'd1 << 32;
    for (int k = 1; k < 48 && term != 0; k++) begin
      term = term * 16 / (64'(TBL) * k);
      if (k & 1) sum = sum - term;
      else sum = sum + term;
    end
    r32 = (sum + (64'd1 << 25)) >> 26;
    for (int k = 0; k <= TBL; k++) begin
      if (k > 0) e = (e * r32 + (64'd1 << 31)) >> 32;
      exp_tab[k] = 32'((e + 64'h8000) >> 16);
    end
  endtask

  function automatic logic [31:0] exp_lookup(logic [63:0] t);
    logic [63:0] p, i, f, a, b;
    p = (t * TBL) >> 4;
    i = p >> 16;
    f = p & 64'hFFFF;
    if (i >= TBL) return exp_tab[TBL];
    a = exp_tab[i];
    b = exp_tab[i+1];
    return 32'(a - (((a - b) * f) >> 16));
  endfunction

  function automatic logic [47:0] predict_height(logic signed [31:0] qx, logic signed [31:0] qy);
    longint acc, ddx, ddy, p;
    logic [63:0] dx, dy, xx, yy, d2, hi, t;
    logic [64:0] d2w;
    int n;
    acc = 0;
    n = act_pts < NPTS ? act_pts : NPTS;
    for (int i = 0; i < n; i++) begin
      ddx = longint'(qx) - longint'(ctr_x[i]);
      ddy = longint'(qy) - longint'(ctr_y[i]);
      dx = ddx < 0 ? -ddx : ddx;
      dy = ddy < 0 ? -ddy : ddy;
      xx = dx * dx;
      yy = dy * dy;
      d2w = {1'b0, xx} + {1'b0, yy};
      d2 = d2w[64] ? '1 : d2w[63:0];
      hi = {32'b0, d2[63:32]} * {32'b0, inv_sig};
      if (hi >= T_SAT) t = T_SAT;
      else begin
        t = hi + (({32'b0, d2[31:0]} * {32'b0, inv_sig}) >> 32);
        if (t > T_SAT) t = T_SAT;
      end
      p = longint'(ctr_w[i]) * longint'({32'b0, exp_lookup(t)});
      acc = acc + (p >>> 16);
      if (acc > H_MAX) acc = H_MAX;
      if (acc < H_MIN) acc = H_MIN;
    end
    return acc[47:0];
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall: random bursts plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_burst <= $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [47:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (height_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected height word %h", height);
      end else begin
        want = height_q.pop_front();
        if (height !== want) begin
          errors++;
          if (errors <= 10) $display("height mismatch: expected %h actual %h", want, height);
        end
      end
    end
  end

  // call at a rising edge; returns at the edge the word is accepted
  task automatic send_word(logic m, logic [5:0] s, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] w);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    slot <= s;
    pos_x <= x;
    pos_y <= y;
    weight <= w;
    do @(posedge clk); while (in_stall);
    if (m == MODE_LOAD) begin
      ctr_x[s] = x;
      ctr_y[s] = y;
      ctr_w[s] = w;
    end else begin
      height_q.push_back(predict_height(x, y));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (height_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_addr <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_INV_SIGMA) inv_sig = val;
    else act_pts = val & 32'h7F;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
      2: return 32'($urandom_range(0, 32'h800000)) - 32'h400000;
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($urandom_range(0, 32'h20000)) - 32'h10000;
    endcase
  endfunction

  function automatic logic [31:0] rand_sigma();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'h10000;
      3: return $urandom_range(1, 32'h400);
      4: return $urandom_range(32'h1000, 32'h40000);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_word(MODE_QUERY, 6'd0, 32'sh0, 32'sh0, 32'sh0);
    send_word(MODE_QUERY, 6'd63, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_fill_store();
    for (int i = 0; i < NPTS; i++)
      send_word(MODE_LOAD, 6'(i), rand_coord(), rand_coord(), $urandom());
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_ACTIVE, 32'd1);
    send_word(MODE_LOAD, 6'd0, 32'sh0, 32'sh0, 32'h7FFFFFFF);
    send_word(MODE_QUERY, 6'd0, 32'sh0, 32'sh0, 32'sh0);
    send_word(MODE_QUERY, 6'd0, 32'sh8000, 32'shFFFF8000, 32'sh0);
    send_word(MODE_LOAD, 6'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_word(MODE_QUERY, 6'd0, 32'h80000000, 32'h80000000, 32'sh0);
    // largest distance saturates the exponent argument
    send_word(MODE_QUERY, 6'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sh0);
    drain();
    write_reg(REG_INV_SIGMA, 32'h0);
    write_reg(REG_ACTIVE, 32'd64);
    send_word(MODE_QUERY, 6'd0, 32'h7FFFFFFF, 32'h80000000, 32'sh0);
    drain();
    write_reg(REG_INV_SIGMA, 32'hFFFFFFFF);
    send_word(MODE_QUERY, 6'd0, 32'sh1, 32'sh0, 32'sh0);
    send_word(MODE_LOAD, 6'd63, 32'sh0, 32'sh1, 32'sh10000);
    send_word(MODE_QUERY, 6'd0, 32'sh0, 32'sh1, 32'sh0);
    drain();
    // more active points than the store holds
    write_reg(REG_ACTIVE, 32'd127);
    write_reg(REG_INV_SIGMA, 32'h10000);
    send_word(MODE_QUERY, 6'd0, 32'sh0, 32'sh0, 32'sh0);
    drain();
    write_reg(REG_ACTIVE, 32'd0);
    send_word(MODE_QUERY, 6'd0, 32'sh10000, 32'sh10000, 32'sh0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_ACTIVE, 32'd8);
    hold_go = 1'b1;
    for (int i = 0; i < 8; i++)
      send_word(MODE_QUERY, 6'($urandom()), rand_coord(), rand_coord(), $urandom());
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == phases - 1) idle_on = 1'b0;
      write_reg(REG_INV_SIGMA, rand_sigma());
      write_reg(REG_ACTIVE, ph == 0 ? 32'd64 : 32'($urandom_range(0, 127)));
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 9) < 4)
          send_word(MODE_LOAD, 6'($urandom()), rand_coord(), rand_coord(), $urandom());
        else
          send_word(MODE_QUERY, 6'($urandom()), rand_coord(), rand_coord(), $urandom());
      end
      drain();
    end
  endtask

  initial begin
    build_exp_table();
    inv_sig = 32'h10000;
    act_pts = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_fill_store();
    test_directed();
    test_backpressure();
    test_random(6, 180);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/grbf_pkg.sv
rtl/grbf_cell.sv
rtl/grbf_eval.sv
rtl/gaussian_rbf_height_interpolator.sv
bench/tb_gaussian_rbf_height_interpolator.sv
